### rtl/nsag_pkg.sv
// Shared constants, register codes and handshake-side status types for the
// strided index address generator. No dependencies.
`default_nettype none

package nsag_pkg;

    localparam int FIELD_DIMS   = 4;   // index fields carried on the ports
    localparam int FSEL_W       = 2;   // selects one of FIELD_DIMS size registers
    localparam int IDX_W        = 12;  // start and current index fields
    localparam int SIZE_W       = 13;  // dimension size registers
    localparam int DIMS_W       = 3;   // dims_in_use register
    localparam int ADDR_W       = 48;  // linear address
    localparam int CFG_IDX_W    = 3;
    localparam int DEF_MAX_DIMS = 4;
    localparam int DEF_DIM_BITS = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS_IN_USE = 3'd0,
        CFG_DIM_SIZE_0  = 3'd1,
        CFG_DIM_SIZE_1  = 3'd2,
        CFG_DIM_SIZE_2  = 3'd3,
        CFG_DIM_SIZE_3  = 3'd4,
        CFG_TRANSPOSED  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_LOAD    = 1'b1
    } op_t;

    // Walk geometry status from the configuration block
    typedef struct packed {
        logic                  busy;
        logic [FIELD_DIMS-1:0] active;
    } geom_t;

    // Per-request status travelling down the address pipeline
    typedef struct packed {
        logic valid;
        logic done;
        logic err;
    } item_stat_t;

endpackage

`default_nettype wire

### rtl/nsag_geometry.sv
// Configuration registers and the stride sequencer: one multiply per dimension
// builds the walk sizes and row-major strides after every register write.
// Depends on nsag_pkg.
`default_nettype none

module nsag_geometry #(
    parameter int LANES    = nsag_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS = nsag_pkg::DEF_DIM_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [nsag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsag_pkg::SIZE_W-1:0]    cfg_data,
    output nsag_pkg::geom_t                geom,
    output logic [nsag_pkg::SIZE_W-1:0]    wsize   [LANES],
    output logic [nsag_pkg::ADDR_W-1:0]    wstride [LANES]
);

    import nsag_pkg::*;

    localparam int CAP_INT = (DIM_BITS >= SIZE_W) ? ((1 << SIZE_W) - 1) : (1 << DIM_BITS);
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP_INT);
    localparam logic [DIMS_W-1:0] LANES_D  = DIMS_W'(LANES);

    logic [DIMS_W-1:0] dims_reg;
    logic [SIZE_W-1:0] size_reg [FIELD_DIMS];
    logic              transposed_reg;
    logic [DIMS_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] acc_reg;
    logic [SIZE_W-1:0] wsize_reg   [LANES];
    logic [ADDR_W-1:0] wstride_reg [LANES];

    logic [DIMS_W-1:0] n_dims;
    logic [DIMS_W-1:0] step_idx;
    logic [DIMS_W-1:0] target;
    logic [SIZE_W-1:0] raw_size;
    logic [SIZE_W-1:0] eff_size;
    logic              step_live;

    always_comb
    begin
        if (dims_reg == '0)
            n_dims = DIMS_W'(1);
        else if (dims_reg > LANES_D)
            n_dims = LANES_D;
        else
            n_dims = dims_reg;
    end

    // Walk from the innermost original dimension outwards
    assign step_idx  = cnt_reg - DIMS_W'(1);
    assign raw_size  = size_reg[step_idx[FSEL_W-1:0]];
    assign eff_size  = (raw_size == '0) ? SIZE_W'(1) :
                       (raw_size > SIZE_CAP) ? SIZE_CAP : raw_size;
    assign step_live = (cnt_reg != '0) && (step_idx < n_dims);
    assign target    = transposed_reg ? (n_dims - DIMS_W'(1) - step_idx) : step_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg       <= DIMS_W'(1);
            transposed_reg <= 1'b0;
            for (int i = 0; i < FIELD_DIMS; i++)
                size_reg[i] <= SIZE_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DIMS_IN_USE: dims_reg       <= cfg_data[DIMS_W-1:0];
                CFG_DIM_SIZE_0:  size_reg[0]    <= cfg_data;
                CFG_DIM_SIZE_1:  size_reg[1]    <= cfg_data;
                CFG_DIM_SIZE_2:  size_reg[2]    <= cfg_data;
                CFG_DIM_SIZE_3:  size_reg[3]    <= cfg_data;
                CFG_TRANSPOSED:  transposed_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Restart the sequence on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            acc_reg <= ADDR_W'(1);
        end
        else if (cfg_wr)
        begin
            cnt_reg <= LANES_D;
            acc_reg <= ADDR_W'(1);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DIMS_W'(1);
            if (step_live)
                acc_reg <= acc_reg * ADDR_W'(eff_size);
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                wsize_reg[k]   <= SIZE_W'(1);
                wstride_reg[k] <= (k == 0) ? ADDR_W'(1) : '0;
            end
            else if (step_live && (target == DIMS_W'(k)))
            begin
                wsize_reg[k]   <= eff_size;
                wstride_reg[k] <= acc_reg;
            end
        end
        assign wsize[k]   = wsize_reg[k];
        assign wstride[k] = wstride_reg[k];
    end

    for (genvar k = 0; k < FIELD_DIMS; k++)
    begin : g_active
        if (k < LANES)
        begin : g_used
            assign geom.active[k] = (k == 0) || (dims_reg > DIMS_W'(k));
        end
        else
        begin : g_unused
            assign geom.active[k] = 1'b0;
        end
    end

    assign geom.busy = (cnt_reg != '0);

endmodule

`default_nettype wire

### rtl/nsag_walker.sv
// Position state and odometer: loads or advances the position on each
// accepted request and holds it as the first pipeline stage. Depends on nsag_pkg.
`default_nettype none

module nsag_walker #(
    parameter int LANES = nsag_pkg::DEF_MAX_DIMS,
    parameter int POS_W = nsag_pkg::DEF_DIM_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        advance,
    input  logic                        operation,
    input  logic [nsag_pkg::IDX_W-1:0]  start_idx [nsag_pkg::FIELD_DIMS],
    input  nsag_pkg::geom_t             geom,
    input  logic [nsag_pkg::SIZE_W-1:0] wsize [LANES],
    output logic [POS_W-1:0]            pos   [LANES],
    output nsag_pkg::item_stat_t        stat
);

    import nsag_pkg::*;

    logic [POS_W-1:0] pos_reg  [LANES];
    logic [POS_W-1:0] pos_next [LANES];
    logic [POS_W-1:0] adv_pos  [LANES];
    logic [POS_W-1:0] hold_pos [LANES];
    logic             done_reg;
    logic             done_next;
    logic             valid_reg;
    logic             err_reg;
    logic             carry;
    logic             wrap_any;
    logic             err_any;
    logic             is_load;
    logic [SIZE_W-1:0] cur;
    logic [SIZE_W-1:0] inc;

    assign is_load = (op_t'(operation) == OP_LOAD);

    // Odometer, innermost walk dimension first; inactive lanes pass the carry
    always_comb
    begin
        carry    = 1'b1;
        wrap_any = 1'b0;
        err_any  = 1'b0;
        cur      = '0;
        inc      = '0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            cur         = SIZE_W'(pos_reg[k]);
            inc         = cur + SIZE_W'(1);
            hold_pos[k] = geom.active[k] ? pos_reg[k] : '0;
            adv_pos[k]  = hold_pos[k];
            if (geom.active[k])
            begin
                if (carry)
                begin
                    if (inc >= wsize[k])
                        adv_pos[k] = '0;
                    else
                    begin
                        adv_pos[k] = POS_W'(inc);
                        carry      = 1'b0;
                    end
                end
                else if (cur >= wsize[k])
                begin
                    // index left past its size by a reconfiguration
                    adv_pos[k] = '0;
                    wrap_any   = 1'b1;
                end
                if (SIZE_W'(start_idx[k]) >= wsize[k])
                    err_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        pos_next  = hold_pos;
        done_next = done_reg;
        if (is_load)
        begin
            if (!err_any)
            begin
                for (int k = 0; k < LANES; k++)
                    pos_next[k] = geom.active[k] ? POS_W'(start_idx[k]) : '0;
                done_next = 1'b0;
            end
        end
        else if (!done_reg)
        begin
            if (carry || wrap_any)
            begin
                for (int k = 0; k < LANES; k++)
                    pos_next[k] = '0;
                done_next = 1'b1;
            end
            else
                pos_next = adv_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int k = 0; k < LANES; k++)
                pos_reg[k] <= '0;
        end
        else if (accept)
        begin
            done_reg <= done_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= accept;
            err_reg   <= accept && is_load && err_any;
        end
    end

    assign pos        = pos_reg;
    assign stat.valid = valid_reg;
    assign stat.done  = done_reg;
    assign stat.err   = err_reg;

endmodule

`default_nettype wire

### rtl/nsag_addr_pipe.sv
// Address pipeline: per-dimension index times stride, a pair-sum stage and
// the output register. Depends on nsag_pkg.
`default_nettype none

module nsag_addr_pipe #(
    parameter int LANES = nsag_pkg::DEF_MAX_DIMS,
    parameter int POS_W = nsag_pkg::DEF_DIM_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  nsag_pkg::item_stat_t        stat_a,
    input  logic [POS_W-1:0]            pos     [LANES],
    input  logic [nsag_pkg::ADDR_W-1:0] wstride [LANES],
    output logic                        out_valid,
    output logic [nsag_pkg::ADDR_W-1:0] linear_address,
    output logic                        walk_done,
    output logic                        bounds_error,
    output logic [nsag_pkg::IDX_W-1:0]  idx [nsag_pkg::FIELD_DIMS]
);

    import nsag_pkg::*;

    localparam int PAIRS = (LANES + 1) / 2;

    logic [IDX_W-1:0]  idx_a    [FIELD_DIMS];
    logic [ADDR_W-1:0] prod_reg [LANES];
    logic [IDX_W-1:0]  b_idx_reg [FIELD_DIMS];
    item_stat_t        b_stat_reg;
    logic [ADDR_W-1:0] pair_next [PAIRS];
    logic [ADDR_W-1:0] pair_reg  [PAIRS];
    logic [IDX_W-1:0]  c_idx_reg [FIELD_DIMS];
    item_stat_t        c_stat_reg;
    logic [ADDR_W-1:0] sum_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [IDX_W-1:0]  d_idx_reg [FIELD_DIMS];
    item_stat_t        d_stat_reg;

    for (genvar k = 0; k < FIELD_DIMS; k++)
    begin : g_idx
        if (k < LANES)
        begin : g_used
            assign idx_a[k] = IDX_W'(pos[k]);
        end
        else
        begin : g_unused
            assign idx_a[k] = '0;
        end
    end

    for (genvar j = 0; j < PAIRS; j++)
    begin : g_pair
        if (2 * j + 1 < LANES)
        begin : g_two
            assign pair_next[j] = prod_reg[2*j] + prod_reg[2*j+1];
        end
        else
        begin : g_one
            assign pair_next[j] = prod_reg[2*j];
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < PAIRS; j++)
            sum_next = sum_next + pair_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_stat_reg <= '0;
            c_stat_reg <= '0;
            d_stat_reg <= '0;
        end
        else if (advance)
        begin
            b_stat_reg <= stat_a;
            c_stat_reg <= b_stat_reg;
            d_stat_reg <= c_stat_reg;
        end
    end

    // Payload moves with the status; no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < LANES; k++)
                prod_reg[k] <= wstride[k] * ADDR_W'(pos[k]);
            pair_reg  <= pair_next;
            addr_reg  <= sum_next;
            b_idx_reg <= idx_a;
            c_idx_reg <= b_idx_reg;
            d_idx_reg <= c_idx_reg;
        end
    end

    assign out_valid      = d_stat_reg.valid;
    assign walk_done      = d_stat_reg.done;
    assign bounds_error   = d_stat_reg.err;
    assign linear_address = addr_reg;
    assign idx            = d_idx_reg;

endmodule

`default_nettype wire

### rtl/nd_strided_index_address_generator.sv
// Top level of the strided index address generator: configuration block,
// position walker and address pipeline. Depends on nsag_pkg and the nsag_* modules.
`default_nettype none

// The generator takes one request per clock and returns one result per
// request, through the position register, the products, the pair sums and
// the output register, with full throughput as long as out_ready stays high;
// a stalled output holds the whole pipeline. A load request sets the start
// position (or flags bounds_error and keeps the old one), an advance request
// steps it in odometer order, innermost walk dimension fastest. After every
// configuration write the stride sequencer steps through each supported
// dimension (four by default) multiplying up the row-major strides; in_ready
// stays low until it finishes. Configuration writes are always taken.
module nd_strided_index_address_generator #(
    parameter int MAX_DIMS = nsag_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS = nsag_pkg::DEF_DIM_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nsag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsag_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [nsag_pkg::IDX_W-1:0]     start_index_0,
    input  logic [nsag_pkg::IDX_W-1:0]     start_index_1,
    input  logic [nsag_pkg::IDX_W-1:0]     start_index_2,
    input  logic [nsag_pkg::IDX_W-1:0]     start_index_3,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nsag_pkg::ADDR_W-1:0]    linear_address,
    output logic                           walk_done,
    output logic                           bounds_error,
    output logic [nsag_pkg::IDX_W-1:0]     index_0,
    output logic [nsag_pkg::IDX_W-1:0]     index_1,
    output logic [nsag_pkg::IDX_W-1:0]     index_2,
    output logic [nsag_pkg::IDX_W-1:0]     index_3
);

    import nsag_pkg::*;

    localparam int LANES = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;
    localparam int POS_W = (DIM_BITS < SIZE_W) ? DIM_BITS : SIZE_W;

    geom_t             geom;
    item_stat_t        stat_a;
    logic [SIZE_W-1:0] wsize   [LANES];
    logic [ADDR_W-1:0] wstride [LANES];
    logic [POS_W-1:0]  pos     [LANES];
    logic [IDX_W-1:0]  start_idx [FIELD_DIMS];
    logic [IDX_W-1:0]  idx       [FIELD_DIMS];
    logic              advance;
    logic              accept;

    assign start_idx[0] = start_index_0;
    assign start_idx[1] = start_index_1;
    assign start_idx[2] = start_index_2;
    assign start_idx[3] = start_index_3;

    // Move the whole pipeline whenever the output slot is free or being taken
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance && !geom.busy;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    nsag_geometry #(
        .LANES    (LANES),
        .DIM_BITS (DIM_BITS)
    ) u_geometry (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .wsize     (wsize),
        .wstride   (wstride)
    );

    nsag_walker #(
        .LANES (LANES),
        .POS_W (POS_W)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .operation (operation),
        .start_idx (start_idx),
        .geom      (geom),
        .wsize     (wsize),
        .pos       (pos),
        .stat      (stat_a)
    );

    nsag_addr_pipe #(
        .LANES (LANES),
        .POS_W (POS_W)
    ) u_addr_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .stat_a         (stat_a),
        .pos            (pos),
        .wstride        (wstride),
        .out_valid      (out_valid),
        .linear_address (linear_address),
        .walk_done      (walk_done),
        .bounds_error   (bounds_error),
        .idx            (idx)
    );

    assign index_0 = idx[0];
    assign index_1 = idx[1];
    assign index_2 = idx[2];
    assign index_3 = idx[3];

    // A register write must hold off requests until the strides are rebuilt
    a_cfg_blocks_requests: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !in_ready)
        else $error("request accepted while strides were being rebuilt");

    // A finished walk always sits at the origin
    a_done_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && walk_done) |-> (linear_address == '0 && index_0 == '0 &&
        index_1 == '0 && index_2 == '0 && index_3 == '0))
        else $error("walk_done with a non-zero position");

endmodule

`default_nettype wire

### tb/nd_strided_index_address_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the strided index address generator: directed table
// followed by randomised phases, each result checked against a fixed expectation or a local walk predictor.
// Depends on nsag_pkg and the nd_strided_index_address_generator RTL.

module nd_strided_index_address_generator_test;

    import nsag_pkg::*;

    localparam int RANDOM_ITEMS = 1926;
    localparam int SIZE_CAP     = 1 << DEF_DIM_BITS;
    localparam int SUPPORTED    = (DEF_MAX_DIMS < FIELD_DIMS) ? DEF_MAX_DIMS : FIELD_DIMS;

    typedef logic [FIELD_DIMS-1:0][IDX_W-1:0] idx_vec_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              done;
        logic              err;
        idx_vec_t          idx;
    } walk_result_t;

    typedef enum logic {
        STEP_CONFIG,
        STEP_REQUEST
    } step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        cfg_reg_t          sel;
        logic [SIZE_W-1:0] data;
        op_t               op;
        idx_vec_t          start;
        logic              fixed;
        walk_result_t      want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 operation;
    logic [IDX_W-1:0]     start_index_0;
    logic [IDX_W-1:0]     start_index_1;
    logic [IDX_W-1:0]     start_index_2;
    logic [IDX_W-1:0]     start_index_3;
    logic                 out_valid;
    logic                 out_ready;
    logic [ADDR_W-1:0]    linear_address;
    logic                 walk_done;
    logic                 bounds_error;
    logic [IDX_W-1:0]     index_0;
    logic [IDX_W-1:0]     index_1;
    logic [IDX_W-1:0]     index_2;
    logic [IDX_W-1:0]     index_3;

    // Predictor copy of the registers and of the walk state
    logic [DIMS_W-1:0] dims_reg;
    logic [SIZE_W-1:0] size_reg [FIELD_DIMS];
    logic              transposed_reg;
    logic [IDX_W-1:0]  cur_pos [FIELD_DIMS];
    logic              at_end;

    walk_result_t pending_results[$];
    step_t        directed_steps[$];
    int           fail_count;
    int           results_seen;
    int           burst_left;

    nd_strided_index_address_generator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .start_index_0  (start_index_0),
        .start_index_1  (start_index_1),
        .start_index_2  (start_index_2),
        .start_index_3  (start_index_3),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .linear_address (linear_address),
        .walk_done      (walk_done),
        .bounds_error   (bounds_error),
        .index_0        (index_0),
        .index_1        (index_1),
        .index_2        (index_2),
        .index_3        (index_3)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int active_dims();
        int n;
        n = int'(dims_reg);
        if (n < 1)
            n = 1;
        if (n > SUPPORTED)
            n = SUPPORTED;
        return n;
    endfunction

    function automatic int clamped_size(int orig);
        int s;
        s = int'(size_reg[orig]);
        if (s < 1)
            s = 1;
        if (s > SIZE_CAP)
            s = SIZE_CAP;
        return s;
    endfunction

    function automatic int walk_orig(int k);
        return transposed_reg ? active_dims() - 1 - k : k;
    endfunction

    function automatic int walk_size(int k);
        return clamped_size(walk_orig(k));
    endfunction

    // Row-major stride of the original dimension behind walk dimension k
    function automatic longint unsigned walk_stride(int k);
        longint unsigned acc;
        int              orig;
        acc  = 1;
        orig = walk_orig(k);
        for (int i = active_dims() - 1; i > orig; i--)
            acc = acc * longint'(clamped_size(i));
        return acc;
    endfunction

    function automatic walk_result_t predict_walk_step(op_t op, idx_vec_t start);
        int              n;
        int              k;
        int              v;
        logic            bad;
        logic            carry;
        longint unsigned sum;
        walk_result_t    r;
        n   = active_dims();
        bad = 1'b0;
        for (k = n; k < FIELD_DIMS; k++)
            cur_pos[k] = '0;
        if (op == OP_LOAD)
        begin
            for (k = 0; k < n; k++)
                if (int'(start[k]) >= walk_size(k))
                    bad = 1'b1;
            if (!bad)
            begin
                for (k = 0; k < n; k++)
                    cur_pos[k] = start[k];
                at_end = 1'b0;
            end
        end
        else if (!at_end)
        begin
            carry = 1'b1;
            k     = n;
            while (k > 0 && carry)
            begin
                v = int'(cur_pos[k-1]) + 1;
                if (v >= walk_size(k - 1))
                    cur_pos[k-1] = '0;
                else
                begin
                    cur_pos[k-1] = v[IDX_W-1:0];
                    carry        = 1'b0;
                end
                k--;
            end
            // an index left beyond a shrunken size wraps to zero and ends the walk
            for (; k > 0; k--)
                if (int'(cur_pos[k-1]) >= walk_size(k - 1))
                begin
                    cur_pos[k-1] = '0;
                    carry        = 1'b1;
                end
            if (carry)
            begin
                for (k = 0; k < n; k++)
                    cur_pos[k] = '0;
                at_end = 1'b1;
            end
        end
        sum = 0;
        for (k = 0; k < n; k++)
            sum = sum + longint'(cur_pos[k]) * walk_stride(k);
        r.addr = sum[ADDR_W-1:0];
        r.done = at_end;
        r.err  = bad;
        for (k = 0; k < FIELD_DIMS; k++)
            r.idx[k] = (k < n) ? cur_pos[k] : '0;
        return r;
    endfunction

    function automatic idx_vec_t starts(int a0, int a1, int a2, int a3);
        idx_vec_t v;
        v[0] = a0[IDX_W-1:0];
        v[1] = a1[IDX_W-1:0];
        v[2] = a2[IDX_W-1:0];
        v[3] = a3[IDX_W-1:0];
        return v;
    endfunction

    function automatic walk_result_t result_of(longint unsigned addr, int done,
                                               int err, idx_vec_t idx);
        walk_result_t r;
        r.addr = addr[ADDR_W-1:0];
        r.done = done[0];
        r.err  = err[0];
        r.idx  = idx;
        return r;
    endfunction

    task automatic queue_step(step_t s);
        directed_steps.insert(directed_steps.size(), s);
    endtask

    task automatic queue_result(walk_result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic add_config(cfg_reg_t sel, int data);
        step_t s;
        s      = '0;
        s.kind = STEP_CONFIG;
        s.sel  = sel;
        s.data = data[SIZE_W-1:0];
        queue_step(s);
    endtask

    task automatic add_request(op_t op, idx_vec_t start);
        step_t s;
        s       = '0;
        s.kind  = STEP_REQUEST;
        s.op    = op;
        s.start = start;
        queue_step(s);
    endtask

    task automatic add_checked(op_t op, idx_vec_t start, walk_result_t want);
        step_t s;
        s       = '0;
        s.kind  = STEP_REQUEST;
        s.op    = op;
        s.start = start;
        s.fixed = 1'b1;
        s.want  = want;
        queue_step(s);
    endtask

    // Offer one request in the current burst; open a new burst after a possible gap when spent
    task automatic send_request(op_t op, idx_vec_t start, logic fixed, walk_result_t want);
        walk_result_t predicted;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        operation     <= op;
        start_index_0 <= start[0];
        start_index_1 <= start[1];
        start_index_2 <= start[2];
        start_index_3 <= start[3];
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predicted = predict_walk_step(op, start);
        queue_result(fixed ? want : predicted);
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t sel, logic [SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        unique case (sel)
            CFG_DIMS_IN_USE: dims_reg       = data[DIMS_W-1:0];
            CFG_DIM_SIZE_0:  size_reg[0]    = data;
            CFG_DIM_SIZE_1:  size_reg[1]    = data;
            CFG_DIM_SIZE_2:  size_reg[2]    = data;
            CFG_DIM_SIZE_3:  size_reg[3]    = data;
            CFG_TRANSPOSED:  transposed_reg = data[0];
            default: ;
        endcase
    endtask

    // Small sizes mostly, so walks wrap often; now and then the out-of-range values
    task automatic random_config();
        int r;
        int sz;
        wait_idle();
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_DIMS_IN_USE,
                      SIZE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                         : $urandom_range(0, 7)));
        for (int i = 0; i < FIELD_DIMS; i++)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    sz = $urandom_range(1, 4);
                else if (r < 80)
                    sz = $urandom_range(1, 16);
                else if (r < 92)
                    sz = $urandom_range(1, SIZE_CAP);
                else
                    sz = $urandom_range(0, (1 << SIZE_W) - 1);
                write_reg(cfg_reg_t'(int'(CFG_DIM_SIZE_0) + i), sz[SIZE_W-1:0]);
            end
        end
        if ($urandom_range(0, 1) != 0)
            write_reg(CFG_TRANSPOSED, SIZE_W'($urandom_range(0, 1)));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int count);
        idx_vec_t     s;
        walk_result_t unused;
        int           r;
        int           m;
        int           sz;
        unused = '0;
        repeat (count)
        begin
            for (int k = 0; k < FIELD_DIMS; k++)
                s[k] = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
            r = $urandom_range(0, 99);
            if (r < 70)
                send_request(OP_ADVANCE, s, 1'b0, unused);
            else
            begin
                for (int k = 0; k < active_dims(); k++)
                begin
                    sz = walk_size(k);
                    m  = $urandom_range(0, 2);
                    if (r < 86)
                        s[k] = IDX_W'((m == 0) ? $urandom_range(0, sz - 1)
                               : sz - 1 - $urandom_range(0, (sz > 3) ? 2 : sz - 1));
                    else if (r >= 95)
                        s[k] = (m == 0) ? '0 : ((m == 1) ? IDX_W'(sz - 1) : '1);
                end
                send_request(OP_LOAD, s, 1'b0, unused);
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: stall pattern in segments, plus two long hold-offs to back up the pipe
    initial
    begin
        int seg_left;
        int stall_pct;
        int hold_left;
        int holds_done;
        out_ready  = 1'b0;
        seg_left   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done < 2 && results_seen >= 400 + holds_done * 900)
            begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(1, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        walk_result_t want;
        idx_vec_t     got_idx;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result 0x%0h returned with no request outstanding", linear_address);
                fail_count++;
            end
            else
            begin
                want    = pending_results.pop_front();
                got_idx = {index_3, index_2, index_1, index_0};
                check_field("linear_address", 64'(want.addr), 64'(linear_address));
                check_field("walk_done", 64'(want.done), 64'(walk_done));
                check_field("bounds_error", 64'(want.err), 64'(bounds_error));
                for (int k = 0; k < FIELD_DIMS; k++)
                    check_field($sformatf("index_%0d", k), 64'(want.idx[k]),
                                64'(got_idx[k]));
                results_seen++;
            end
        end
    end

    initial
    begin
        logic in_cfg;
        int   sent;
        int   n;
        int   spins;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_DIMS_IN_USE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        operation      = OP_ADVANCE;
        start_index_0  = '0;
        start_index_1  = '0;
        start_index_2  = '0;
        start_index_3  = '0;
        fail_count     = 0;
        results_seen   = 0;
        burst_left     = 0;
        dims_reg       = DIMS_W'(1);
        transposed_reg = 1'b0;
        at_end         = 1'b0;
        for (int k = 0; k < FIELD_DIMS; k++)
        begin
            size_reg[k] = SIZE_W'(1);
            cur_pos[k]  = '0;
        end

        // Reset geometry: one dimension of size one
        add_checked(OP_LOAD, starts(0, 0, 0, 0), result_of(0, 0, 0, '0));
        add_checked(OP_ADVANCE, starts(0, 0, 0, 0), result_of(0, 1, 0, '0));
        add_checked(OP_ADVANCE, starts(0, 0, 0, 0), result_of(0, 1, 0, '0));
        add_checked(OP_LOAD, starts(1, 0, 0, 0), result_of(0, 1, 1, '0));
        add_checked(OP_LOAD, starts(0, 4095, 4095, 4095), result_of(0, 0, 0, '0));
        // Full-size tensor: extreme address, wrap, hold while done
        add_config(CFG_DIMS_IN_USE, 4);
        add_config(CFG_DIM_SIZE_0, 4096);
        add_config(CFG_DIM_SIZE_1, 4096);
        add_config(CFG_DIM_SIZE_2, 4096);
        add_config(CFG_DIM_SIZE_3, 4096);
        add_config(CFG_TRANSPOSED, 0);
        add_checked(OP_LOAD, starts(4095, 4095, 4095, 4095),
                    result_of('1, 0, 0, starts(4095, 4095, 4095, 4095)));
        add_checked(OP_ADVANCE, starts(0, 0, 0, 0), result_of(0, 1, 0, '0));
        add_checked(OP_ADVANCE, starts(0, 0, 0, 0), result_of(0, 1, 0, '0));
        add_checked(OP_LOAD, starts(0, 0, 0, 0), result_of(0, 0, 0, '0));
        add_checked(OP_ADVANCE, starts(0, 0, 0, 0), result_of(1, 0, 0, starts(0, 0, 0, 1)));
        // Column-major walk over uneven sizes
        add_config(CFG_DIM_SIZE_0, 3);
        add_config(CFG_DIM_SIZE_1, 5);
        add_config(CFG_DIM_SIZE_2, 7);
        add_config(CFG_DIM_SIZE_3, 2);
        add_config(CFG_TRANSPOSED, 1);
        add_request(OP_LOAD, starts(1, 6, 4, 2));
        add_request(OP_LOAD, starts(2, 0, 0, 0));
        repeat (4) add_request(OP_ADVANCE, starts(0, 0, 0, 0));
        // Zero dimension count and oversize extent clamp
        add_config(CFG_DIMS_IN_USE, 0);
        add_config(CFG_DIM_SIZE_0, 8191);
        add_config(CFG_TRANSPOSED, 0);
        add_checked(OP_LOAD, starts(4095, 7, 7, 7), result_of(4095, 0, 0, starts(4095, 0, 0, 0)));
        add_checked(OP_ADVANCE, starts(0, 0, 0, 0), result_of(0, 1, 0, '0));
        // Count above the supported maximum, zero size, then shrink under live indices
        add_config(CFG_DIMS_IN_USE, 7);
        add_config(CFG_DIM_SIZE_0, 0);
        add_config(CFG_DIM_SIZE_1, 2);
        add_config(CFG_DIM_SIZE_2, 1);
        add_config(CFG_DIM_SIZE_3, 4097);
        add_request(OP_LOAD, starts(0, 1, 0, 10));
        add_request(OP_LOAD, starts(0, 2, 0, 0));
        add_config(CFG_DIM_SIZE_1, 1);
        add_request(OP_ADVANCE, starts(0, 0, 0, 0));
        add_request(OP_LOAD, starts(0, 0, 0, 4095));
        add_config(CFG_DIM_SIZE_3, 3);
        add_config(CFG_TRANSPOSED, 1);
        add_request(OP_ADVANCE, starts(0, 0, 0, 0));
        add_request(OP_ADVANCE, starts(0, 0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        in_cfg = 1'b0;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_CONFIG)
            begin
                if (!in_cfg)
                begin
                    wait_idle();
                    in_cfg = 1'b1;
                end
                write_reg(directed_steps[i].sel, directed_steps[i].data);
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_valid <= 1'b0;
                    in_cfg    = 1'b0;
                end
                send_request(directed_steps[i].op, directed_steps[i].start,
                             directed_steps[i].fixed, directed_steps[i].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            n = $urandom_range(40, 200);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            random_config();
            random_requests(n);
            sent += n;
        end
        in_valid <= 1'b0;

        spins = 0;
        while (pending_results.size() != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (12) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d requests never produced a result", pending_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
